// ===== rtl/bpmc_pkg.sv =====
// shared constants and types for the box pair match cost block
package bpmc_pkg;

	localparam int          CFG_INDEX_W = 2;
	localparam int          THR_W       = 16;
	localparam int          WGT_W       = 17;
	localparam int          COST_W      = 17;
	localparam int          FRAC_W      = 16;
	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [4:0]  PIXEL_UNITS = 5'd16;
	localparam logic [15:0] THR_RESET   = 16'd1600;
	localparam logic [16:0] WGT_RESET   = 17'd32768;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WEIGHT    = 2'd1
	} reg_index_t;

endpackage

// ===== rtl/bpmc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module bpmc_div #(
	parameter int DEN_W  = 16,
	parameter int QUO_W  = 17,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DEN_W-1:0]  in_rem,
	input  logic [QUO_W-1:0]  in_low,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic              valid_s [1:QUO_W];
	logic [DEN_W-1:0]  rem_s   [1:QUO_W];
	logic [QUO_W-1:0]  low_s   [1:QUO_W];
	logic [DEN_W-1:0]  den_s   [1:QUO_W];
	logic [QUO_W-1:0]  quo_s   [1:QUO_W];
	logic [SIDE_W-1:0] side_s  [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic              cur_valid;
		logic [DEN_W-1:0]  cur_rem;
		logic [QUO_W-1:0]  cur_low;
		logic [DEN_W-1:0]  cur_den;
		logic [QUO_W-1:0]  cur_quo;
		logic [SIDE_W-1:0] cur_side;
		logic [DEN_W:0]    shl;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_valid = in_valid;
			assign cur_rem   = in_rem;
			assign cur_low   = in_low;
			assign cur_den   = in_den;
			assign cur_quo   = '0;
			assign cur_side  = in_side;
		end else begin : g_next
			assign cur_valid = valid_s[k];
			assign cur_rem   = rem_s[k];
			assign cur_low   = low_s[k];
			assign cur_den   = den_s[k];
			assign cur_quo   = quo_s[k];
			assign cur_side  = side_s[k];
		end

		assign shl = {cur_rem, cur_low[QUO_W-1]};
		assign ge  = shl >= {1'b0, cur_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (ge) begin
				rem_s[k+1] <= DEN_W'(shl - {1'b0, cur_den});
			end else begin
				rem_s[k+1] <= shl[DEN_W-1:0];
			end
			low_s[k+1]  <= {cur_low[QUO_W-2:0], 1'b0};
			den_s[k+1]  <= cur_den;
			quo_s[k+1]  <= {cur_quo[QUO_W-2:0], ge};
			side_s[k+1] <= cur_side;
		end
	end

	assign out_valid = valid_s[QUO_W];
	assign out_quo   = quo_s[QUO_W];
	assign out_side  = side_s[QUO_W];

endmodule

// ===== rtl/bpmc_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module bpmc_isqrt #(
	parameter int IN_W   = 36,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [IN_W-1:0]     in_sq,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output logic [IN_W/2-1:0]   out_root,
	output logic [SIDE_W-1:0]   out_side
);

	localparam int RES_W = IN_W / 2;

	logic              valid_s [1:RES_W];
	logic [IN_W-1:0]   sq_s    [1:RES_W];
	logic [RES_W:0]    rem_s   [1:RES_W];
	logic [RES_W-1:0]  root_s  [1:RES_W];
	logic [SIDE_W-1:0] side_s  [1:RES_W];

	for (genvar k = 0; k < RES_W; k++) begin : g_stage
		logic              cur_valid;
		logic [IN_W-1:0]   cur_sq;
		logic [RES_W:0]    cur_rem;
		logic [RES_W-1:0]  cur_root;
		logic [SIDE_W-1:0] cur_side;
		logic [RES_W+2:0]  rem4;
		logic [RES_W+2:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_valid = in_valid;
			assign cur_sq    = in_sq;
			assign cur_rem   = '0;
			assign cur_root  = '0;
			assign cur_side  = in_side;
		end else begin : g_next
			assign cur_valid = valid_s[k];
			assign cur_sq    = sq_s[k];
			assign cur_rem   = rem_s[k];
			assign cur_root  = root_s[k];
			assign cur_side  = side_s[k];
		end

		assign rem4  = {cur_rem, cur_sq[IN_W-1:IN_W-2]};
		assign trial = {1'b0, cur_root, 2'b01};
		assign ge    = rem4 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (ge) begin
				rem_s[k+1] <= (RES_W+1)'(rem4 - trial);
			end else begin
				rem_s[k+1] <= rem4[RES_W:0];
			end
			sq_s[k+1]   <= {cur_sq[IN_W-3:0], 2'b00};
			root_s[k+1] <= {cur_root[RES_W-2:0], ge};
			side_s[k+1] <= cur_side;
		end
	end

	assign out_valid = valid_s[RES_W];
	assign out_root  = root_s[RES_W];
	assign out_side  = side_s[RES_W];

endmodule

// ===== rtl/box_pair_match_cost_top.sv =====
// top level of the box pair match cost pipeline
//
// channel   direction  handshake            payload
// command   in         start (busy low)     a_left .. b_bottom
// result    out        done, one cycle      match_cost
// config    in         cfg_we               cfg_index, cfg_data
//
// one transaction per cycle; busy stays low, the pipeline never stops
// the path holds 16 fraction steps, COORD_BITS + 2 root
// steps and 17 score division steps, plus seven front, multiply and output stages
// reset clears valid bits and loads the register defaults
// the receiver cannot stall; results leave on done for one cycle
module box_pair_match_cost_top #(
	parameter int COORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [COORD_BITS-1:0]                a_left,
	input  logic [COORD_BITS-1:0]                a_top,
	input  logic [COORD_BITS-1:0]                a_right,
	input  logic [COORD_BITS-1:0]                a_bottom,
	input  logic [COORD_BITS-1:0]                b_left,
	input  logic [COORD_BITS-1:0]                b_top,
	input  logic [COORD_BITS-1:0]                b_right,
	input  logic [COORD_BITS-1:0]                b_bottom,
	output logic                                 done,
	output logic [bpmc_pkg::COST_W-1:0]          match_cost,
	input  logic                                 cfg_we,
	input  logic [bpmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bpmc_pkg::WGT_W-1:0]           cfg_data
);

	localparam int CW = COORD_BITS;
	localparam int SW = CW + 1;
	localparam int DW = CW + 2;
	localparam int PW = 2 * CW + 2;
	localparam int UW = 2 * CW + 3;
	localparam int IW = 2 * CW + 4;
	localparam int RW = CW + 2;
	localparam int ZW = CW + 17;
	localparam int TW = bpmc_pkg::THR_W;
	localparam int WW = bpmc_pkg::WGT_W;
	localparam int NW = TW + WW;

	logic [TW-1:0] thr_q;
	logic [WW-1:0] wgt_q;
	logic [WW-1:0] wgt_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= bpmc_pkg::THR_RESET;
			wgt_q <= bpmc_pkg::WGT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpmc_pkg::REG_THRESHOLD: thr_q <= cfg_data[TW-1:0];
				bpmc_pkg::REG_WEIGHT:    wgt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign wgt_eff = (wgt_q > bpmc_pkg::ONE_Q16) ? bpmc_pkg::ONE_Q16 : wgt_q;
	assign busy    = 1'b0;

	// stage 1: capture
	logic          valid_s1;
	logic [CW-1:0] al_s1, at_s1, ar_s1, ab_s1, bl_s1, bt_s1, br_s1, bb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		al_s1 <= a_left;
		at_s1 <= a_top;
		ar_s1 <= a_right;
		ab_s1 <= a_bottom;
		bl_s1 <= b_left;
		bt_s1 <= b_top;
		br_s1 <= b_right;
		bb_s1 <= b_bottom;
	end

	// stage 2: centre offsets, overlap extents and box sizes
	logic [SW-1:0]        sax, sbx, say, sby, ux, uy;
	logic [CW-1:0]        min_r, max_l, min_b, max_t;
	logic signed [DW-1:0] iw, ih;
	logic [DW-1:0]        wa, ha, wb, hb;

	assign sax = SW'(al_s1) + SW'(ar_s1);
	assign sbx = SW'(bl_s1) + SW'(br_s1);
	assign say = SW'(at_s1) + SW'(ab_s1);
	assign sby = SW'(bt_s1) + SW'(bb_s1);
	assign ux  = (sax >= sbx) ? (sax - sbx) : (sbx - sax);
	assign uy  = (say >= sby) ? (say - sby) : (sby - say);

	assign min_r = (ar_s1 < br_s1) ? ar_s1 : br_s1;
	assign max_l = (al_s1 > bl_s1) ? al_s1 : bl_s1;
	assign min_b = (ab_s1 < bb_s1) ? ab_s1 : bb_s1;
	assign max_t = (at_s1 > bt_s1) ? at_s1 : bt_s1;
	assign iw = $signed(DW'(min_r) - DW'(max_l) + DW'(bpmc_pkg::PIXEL_UNITS));
	assign ih = $signed(DW'(min_b) - DW'(max_t) + DW'(bpmc_pkg::PIXEL_UNITS));
	assign wa = DW'(ar_s1) - DW'(al_s1) + DW'(bpmc_pkg::PIXEL_UNITS);
	assign ha = DW'(ab_s1) - DW'(at_s1) + DW'(bpmc_pkg::PIXEL_UNITS);
	assign wb = DW'(br_s1) - DW'(bl_s1) + DW'(bpmc_pkg::PIXEL_UNITS);
	assign hb = DW'(bb_s1) - DW'(bt_s1) + DW'(bpmc_pkg::PIXEL_UNITS);

	logic          valid_s2, ov_s2;
	logic [SW-1:0] ux_s2, uy_s2, iw_s2, ih_s2, wa_s2, ha_s2, wb_s2, hb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ov_s2 <= (iw > 0) && (ih > 0);
		ux_s2 <= ux;
		uy_s2 <= uy;
		iw_s2 <= iw[SW-1:0];
		ih_s2 <= ih[SW-1:0];
		wa_s2 <= wa[SW-1:0];
		ha_s2 <= ha[SW-1:0];
		wb_s2 <= wb[SW-1:0];
		hb_s2 <= hb[SW-1:0];
	end

	// stage 3: products
	logic          valid_s3, ov_s3;
	logic [PW-1:0] sqx_s3, sqy_s3, inter_s3, area_a_s3, area_b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ov_s3     <= ov_s2;
		sqx_s3    <= PW'(ux_s2) * PW'(ux_s2);
		sqy_s3    <= PW'(uy_s2) * PW'(uy_s2);
		inter_s3  <= PW'(iw_s2) * PW'(ih_s2);
		area_a_s3 <= PW'(wa_s2) * PW'(ha_s2);
		area_b_s3 <= PW'(wb_s2) * PW'(hb_s2);
	end

	// stage 4: sums, union and fraction operands
	logic [UW-1:0] uni, inter_w;
	logic          full;

	assign inter_w = UW'(inter_s3);
	assign uni     = UW'(area_a_s3) + UW'(area_b_s3) - inter_w;
	assign full    = ov_s3 && (inter_w >= uni);

	logic          valid_s4, full_s4;
	logic [UW-1:0] sum_sq_s4, num_s4, den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sum_sq_s4 <= UW'(sqx_s3) + UW'(sqy_s3);
		full_s4   <= full;
		num_s4    <= (ov_s3 && !full) ? inter_w : '0;
		den_s4    <= ov_s3 ? uni : UW'(1);
	end

	// iou fraction
	logic                        frac_valid;
	logic [bpmc_pkg::FRAC_W-1:0] frac_quo;
	logic [UW:0]                 frac_side;

	bpmc_div #(
		.DEN_W  (UW),
		.QUO_W  (bpmc_pkg::FRAC_W),
		.SIDE_W (UW + 1)
	) u_frac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.in_rem    (num_s4),
		.in_low    ('0),
		.in_den    (den_s4),
		.in_side   ({full_s4, sum_sq_s4}),
		.out_valid (frac_valid),
		.out_quo   (frac_quo),
		.out_side  (frac_side)
	);

	// stage 5: iou term
	logic [WW-1:0]   iou;
	logic [2*WW-1:0] iou_prod;

	assign iou      = frac_side[UW] ? bpmc_pkg::ONE_Q16 : WW'(frac_quo);
	assign iou_prod = (2*WW)'(iou) * (2*WW)'(bpmc_pkg::ONE_Q16 - wgt_eff);

	logic          valid_s5;
	logic [WW-1:0] iou_term_s5;
	logic [UW-1:0] sum_sq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= frac_valid;
		end
	end

	always_ff @(posedge clk) begin
		iou_term_s5 <= iou_prod[16 +: WW];
		sum_sq_s5   <= frac_side[UW-1:0];
	end

	// centre distance
	logic          sqrt_valid;
	logic [RW-1:0] sqrt_root;
	logic [WW-1:0] sqrt_side;

	bpmc_isqrt #(
		.IN_W   (IW),
		.SIDE_W (WW)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s5),
		.in_sq     ({1'b0, sum_sq_s5}),
		.in_side   (iou_term_s5),
		.out_valid (sqrt_valid),
		.out_root  (sqrt_root),
		.out_side  (sqrt_side)
	);

	// stage 6: distance score operands
	logic [ZW-1:0] dist_z, thr_z;
	logic [TW-1:0] gap;

	assign dist_z = ZW'(sqrt_root[RW-1:1]);
	assign thr_z  = ZW'(thr_q);
	assign gap    = TW'(thr_z - dist_z);

	logic          valid_s6;
	logic [NW-1:0] num_s6;
	logic [TW-1:0] den_s6;
	logic [WW-1:0] iou_term_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= sqrt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (thr_q == '0) begin
			num_s6 <= (dist_z == '0) ? NW'(wgt_eff) : '0;
			den_s6 <= TW'(1);
		end else begin
			num_s6 <= (dist_z <= thr_z) ? NW'(gap) * NW'(wgt_eff) : '0;
			den_s6 <= thr_q;
		end
		iou_term_s6 <= sqrt_side;
	end

	// distance score division
	logic          div_valid;
	logic [WW-1:0] div_quo;
	logic [WW-1:0] div_side;

	bpmc_div #(
		.DEN_W  (TW),
		.QUO_W  (WW),
		.SIDE_W (WW)
	) u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s6),
		.in_rem    (num_s6[NW-1:WW]),
		.in_low    (num_s6[WW-1:0]),
		.in_den    (den_s6),
		.in_side   (iou_term_s6),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	// output register
	logic [WW:0]   score;
	logic [WW-1:0] score_sat;

	assign score     = (WW+1)'(div_quo) + (WW+1)'(div_side);
	assign score_sat = (score > (WW+1)'(bpmc_pkg::ONE_Q16)) ? bpmc_pkg::ONE_Q16 : score[WW-1:0];

	logic          done_q;
	logic [WW-1:0] match_cost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		match_cost_q <= bpmc_pkg::ONE_Q16 - score_sat;
	end

	assign done       = done_q;
	assign match_cost = match_cost_q;

`ifndef SYNTH
	a_cost_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> match_cost <= bpmc_pkg::ONE_Q16)
		else $error("match cost above one");
	a_weight_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		wgt_eff <= bpmc_pkg::ONE_Q16)
		else $error("weight not clamped");
	a_div_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid |=> done)
		else $error("score lost before output");
	a_front_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> ##2 valid_s4)
		else $error("transaction lost in front stages");
`endif

endmodule
